// File: src/spc_pkg.sv
// Shared types and codes for the shape pair collision test block.
// Used by spc_seg_unit and shape_pair_collision_test_top; depends on nothing.
package spc_pkg;

   // Default coordinate width: signed Q12.4.
   localparam int COORD_BITS_DEFAULT = 16;

   // Shape kinds as they arrive on the request channel.
   typedef enum logic [1:0] {
      KIND_BOX    = 2'd0,
      KIND_CIRCLE = 2'd1,
      KIND_LINE   = 2'd2,
      KIND_POINT  = 2'd3
   } kind_type;

   // Ordered pair of kinds, first kind in the upper two bits.
   typedef logic [3:0] pair_type;

   localparam pair_type PAIR_BOX_BOX       = {KIND_BOX, KIND_BOX};
   localparam pair_type PAIR_BOX_CIRCLE    = {KIND_BOX, KIND_CIRCLE};
   localparam pair_type PAIR_BOX_LINE      = {KIND_BOX, KIND_LINE};
   localparam pair_type PAIR_BOX_POINT     = {KIND_BOX, KIND_POINT};
   localparam pair_type PAIR_CIRCLE_CIRCLE = {KIND_CIRCLE, KIND_CIRCLE};
   localparam pair_type PAIR_CIRCLE_LINE   = {KIND_CIRCLE, KIND_LINE};
   localparam pair_type PAIR_CIRCLE_POINT  = {KIND_CIRCLE, KIND_POINT};
   localparam pair_type PAIR_LINE_LINE     = {KIND_LINE, KIND_LINE};
   localparam pair_type PAIR_LINE_POINT    = {KIND_LINE, KIND_POINT};
   localparam pair_type PAIR_POINT_POINT   = {KIND_POINT, KIND_POINT};

   // Load enables for the three pipeline stages inside a segment unit.
   typedef struct packed {
      logic adv3;
      logic adv4;
      logic adv5;
   } seg_ctl_type;

endpackage

// File: src/spc_seg_unit.sv
// Segment against segment crossing test, three pipeline stages.
// Depends on spc_pkg for the stage enable struct.
module spc_seg_unit #(
   parameter int COORD_BITS = spc_pkg::COORD_BITS_DEFAULT,
   localparam int DW = COORD_BITS + 2
) (
   input  logic                 clock,
   input  spc_pkg::seg_ctl_type ctl,
   input  logic [DW-1:0]        adx,
   input  logic [DW-1:0]        ady,
   input  logic [DW-1:0]        bdx,
   input  logic [DW-1:0]        bdy,
   input  logic [DW-1:0]        ox,
   input  logic [DW-1:0]        oy,
   output logic                 hit
);
   localparam int PW = 2 * DW;
   localparam int SW = PW + 2;

   function automatic logic [PW-1:0] smul(input logic [DW-1:0] a, input logic [DW-1:0] b);
      smul = PW'($signed(a)) * PW'($signed(b));
   endfunction

   function automatic logic [SW-1:0] ext(input logic [PW-1:0] v);
      ext = {{(SW-PW){v[PW-1]}}, v};
   endfunction

   function automatic logic nonpos(input logic [SW-1:0] v);
      nonpos = v[SW-1] || (v == '0);
   endfunction

   logic [PW-1:0] m_in [6];
   logic [PW-1:0] m_ff [6];
   logic [SW-1:0] den_in, na_in, nb_in, nad_in, nbd_in;
   logic [SW-1:0] den_ff, na_ff, nb_ff, nad_ff, nbd_ff;
   logic          pos;
   logic          hit_in, hit_ff;

   // Products of the cross terms.
   assign m_in[0] = smul(bdy, adx);
   assign m_in[1] = smul(bdx, ady);
   assign m_in[2] = smul(bdx, oy);
   assign m_in[3] = smul(bdy, ox);
   assign m_in[4] = smul(adx, oy);
   assign m_in[5] = smul(ady, ox);

   always_ff @(posedge clock) begin
      if (ctl.adv3) begin
         m_ff <= m_in;
      end
   end

   // Denominator, both numerators and their distance to the denominator.
   assign den_in = ext(m_ff[0]) - ext(m_ff[1]);
   assign na_in  = ext(m_ff[2]) - ext(m_ff[3]);
   assign nb_in  = ext(m_ff[4]) - ext(m_ff[5]);
   assign nad_in = ext(m_ff[2]) - ext(m_ff[3]) - ext(m_ff[0]) + ext(m_ff[1]);
   assign nbd_in = ext(m_ff[4]) - ext(m_ff[5]) - ext(m_ff[0]) + ext(m_ff[1]);

   always_ff @(posedge clock) begin
      if (ctl.adv4) begin
         den_ff <= den_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
         nad_ff <= nad_in;
         nbd_ff <= nbd_in;
      end
   end

   // Both parameters must lie in [0, 1]; the sign of the denominator
   // flips the direction of every bound. Parallel segments never cross.
   assign pos = !den_ff[SW-1];
   assign hit_in = (den_ff != '0) &&
      (pos ? (!na_ff[SW-1] && nonpos(nad_ff) && !nb_ff[SW-1] && nonpos(nbd_ff))
           : (nonpos(na_ff) && !nad_ff[SW-1] && nonpos(nb_ff) && !nbd_ff[SW-1]));

   always_ff @(posedge clock) begin
      if (ctl.adv5) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

// File: src/shape_pair_collision_test_top.sv
// Shape pair collision test: top level with a seven stage pipeline.
// Depends on spc_pkg and instantiates four spc_seg_unit blocks.
//
// Each request transaction carries two shapes (box, circle, line segment
// or point) in signed fixed point, and gives exactly one response
// transaction with the hit flag. The two shapes may arrive in any order;
// the block sorts them by kind on entry.
// A transaction is taken on a rising edge with req_valid high and
// req_stall low, and is delivered on an edge with rsp_valid high and
// rsp_stall low.
// Throughput is one transaction per clock while the receiver does not
// stall. A transaction passes through seven register stages on its way
// from the accepting edge to rsp. The depth is set by the multiplier
// stages, where the circle against segment test squares a cross product
// through split partial products.
// Every stage holds its own valid bit. When the receiver stalls, only
// stages that hold data and sit behind the blocked output wait; empty
// stages keep filling, so new transactions are still taken until the
// pipeline is full. Reset clears all valid bits and drops no other state.
module shape_pair_collision_test_top #(
   parameter int COORD_BITS = spc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind_a,
   input  logic [1:0]                   req_kind_b,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_a_p3,
   input  logic signed [COORD_BITS-1:0] req_a_p4,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_b_p3,
   input  logic signed [COORD_BITS-1:0] req_b_p4,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit
);
   import spc_pkg::*;

   localparam int W  = COORD_BITS;
   localparam int DW = W + 2;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 2;
   localparam int LW = 2 * PW + 2;

   typedef struct packed {
      pair_type     pair;
      logic [W-1:0] ax, ay, ap, aq, bx, by, bp, bq;
   } s1_type;

   typedef struct packed {
      logic [DW-1:0] adx, ady, bdx, bdy, ox, oy;
   } seg_ops_type;

   typedef struct packed {
      pair_type          pair;
      logic              pre;
      logic              rneg;
      logic [DW-1:0]     w0x, w0y, w0r, w1x, w1y, pdx, pdy, pex, pey;
      seg_ops_type [3:0] seg;
   } s2_type;

   typedef struct packed {
      pair_type      pair;
      logic          pre;
      logic          rneg;
      logic [PW-1:0] w0xx, w0yy, rr, w1xx, w1yy, pxx, pyy, pxd, pyd, pc1, pc2;
   } s3_type;

   typedef struct packed {
      pair_type      pair;
      logic          pre;
      logic          rneg;
      logic [SW-1:0] w0d, w1d, len2, dot, dml, cr;
      logic [PW-1:0] rr;
   } s4_type;

   typedef struct packed {
      pair_type      pair;
      logic          pre;
      logic          w0hit;
      logic          w1hit;
      logic          rneg;
      logic          segpt;
      logic          projok;
      logic [PW-1:0] crmag, len2m, rsq;
   } s5_type;

   typedef struct packed {
      logic          base;
      logic          need;
      logic [PW-1:0] chh, chl, cll, phh, phl, plh, pll;
   } s6_type;

   function automatic logic signed [DW-1:0] sext(input logic [W-1:0] v);
      sext = {{(DW-W){v[W-1]}}, v};
   endfunction

   function automatic logic [PW-1:0] smul(input logic [DW-1:0] a, input logic [DW-1:0] b);
      smul = PW'($signed(a)) * PW'($signed(b));
   endfunction

   function automatic logic [SW-1:0] ext(input logic [PW-1:0] v);
      ext = {{(SW-PW){v[PW-1]}}, v};
   endfunction

   function automatic logic nonpos(input logic [SW-1:0] v);
      nonpos = v[SW-1] || (v == '0);
   endfunction

   logic [7:1]  valid_ff;
   logic [7:1]  adv;
   s1_type      s1_in, s1_ff;
   s2_type      s2_in, s2_ff;
   s3_type      s3_in, s3_ff;
   s4_type      s4_in, s4_ff;
   s5_type      s5_in, s5_ff;
   s6_type      s6_in, s6_ff;
   logic        hit_in, hit_ff;
   logic        swap;
   seg_ctl_type seg_ctl;
   logic [3:0]  seg_hit;

   // Stage advance: a stage loads when it is empty or its successor moves.
   always_comb begin
      adv[7] = !valid_ff[7] || !rsp_stall;
      for (int i = 6; i >= 1; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[1];
   assign rsp_valid = valid_ff[7];
   assign rsp_hit   = hit_ff;
   assign seg_ctl   = {adv[3], adv[4], adv[5]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) valid_ff[1] <= req_valid;
         for (int i = 2; i <= 7; i++) begin
            if (adv[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Stage 1: sort the two shapes so that the lower kind comes first.
   assign swap = req_kind_a > req_kind_b;

   always_comb begin
      if (swap) begin
         s1_in.pair = {req_kind_b, req_kind_a};
         s1_in.ax = req_b_x;  s1_in.ay = req_b_y;  s1_in.ap = req_b_p3; s1_in.aq = req_b_p4;
         s1_in.bx = req_a_x;  s1_in.by = req_a_y;  s1_in.bp = req_a_p3; s1_in.bq = req_a_p4;
      end else begin
         s1_in.pair = {req_kind_a, req_kind_b};
         s1_in.ax = req_a_x;  s1_in.ay = req_a_y;  s1_in.ap = req_a_p3; s1_in.aq = req_a_p4;
         s1_in.bx = req_b_x;  s1_in.by = req_b_y;  s1_in.bp = req_b_p3; s1_in.bq = req_b_p4;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) s1_ff <= s1_in;
   end

   // Stage 2: box extents, bound tests, clamping and operand differences.
   logic signed [DW-1:0] ax, ay, ap, aq, bx, by, bp, bq, ax2, ay2, bx2, by2;
   logic signed [DW-1:0] c1x, c2x, c1y, c2y, clx, cly, w0r;
   logic signed [DW-1:0] psx, psy, ppx, ppy, ptx, pty;
   logic signed [DW-1:0] ex1 [4];
   logic signed [DW-1:0] ey1 [4];
   logic signed [DW-1:0] ex2 [4];
   logic signed [DW-1:0] ey2 [4];
   logic                 in_box0, in_box1, box_ovl, line_pair, lp;

   assign ax = sext(s1_ff.ax);
   assign ay = sext(s1_ff.ay);
   assign ap = sext(s1_ff.ap);
   assign aq = sext(s1_ff.aq);
   assign bx = sext(s1_ff.bx);
   assign by = sext(s1_ff.by);
   assign bp = sext(s1_ff.bp);
   assign bq = sext(s1_ff.bq);
   assign ax2 = ax + ap;
   assign ay2 = ay + aq;
   assign bx2 = bx + bp;
   assign by2 = by + bq;

   // Inclusive bound tests against the first shape as a box.
   assign in_box0 = !(ax2 < bx) && !(ax > bx) && !(ay2 < by) && !(ay > by);
   assign in_box1 = !(ax2 < bp) && !(ax > bp) && !(ay2 < bq) && !(ay > bq);
   assign box_ovl = !(ay2 < by) && !(ay > by2) && !(ax2 < bx) && !(ax > bx2);

   // Circle centre clamped to the box, as an offset from the centre.
   assign c1x = ax - bx;
   assign c2x = ax2 - bx;
   assign c1y = ay - by;
   assign c2y = ay2 - by;
   assign clx = (c1x > 0) ? c1x : ((c2x < 0) ? c2x : '0);
   assign cly = (c1y > 0) ? c1y : ((c2y < 0) ? c2y : '0);

   // The four box edges; the first unit takes the other segment for two lines.
   assign line_pair = s1_ff.pair == PAIR_LINE_LINE;
   assign ex1[0] = ax;  assign ey1[0] = ay;
   assign ex2[0] = line_pair ? ap : ax;
   assign ey2[0] = line_pair ? aq : ay2;
   assign ex1[1] = ax2; assign ey1[1] = ay;  assign ex2[1] = ax2; assign ey2[1] = ay2;
   assign ex1[2] = ax;  assign ey1[2] = ay;  assign ex2[2] = ax2; assign ey2[2] = ay;
   assign ex1[3] = ax;  assign ey1[3] = ay2; assign ex2[3] = ax2; assign ey2[3] = ay2;

   // Projection operands: segment and point, for line-point or circle-line.
   assign lp  = s1_ff.pair == PAIR_LINE_POINT;
   assign psx = lp ? ax : bx;
   assign psy = lp ? ay : by;
   assign ppx = lp ? ap : bp;
   assign ppy = lp ? aq : bq;
   assign ptx = lp ? bx : ax;
   assign pty = lp ? by : ay;

   always_comb begin
      unique case (s1_ff.pair)
         PAIR_BOX_CIRCLE:    w0r = bp;
         PAIR_CIRCLE_CIRCLE: w0r = ap + bp;
         default:            w0r = ap;
      endcase
   end

   always_comb begin
      s2_in.pair = s1_ff.pair;
      unique case (s1_ff.pair)
         PAIR_BOX_BOX:     s2_in.pre = box_ovl;
         PAIR_BOX_POINT:   s2_in.pre = in_box0;
         PAIR_BOX_LINE:    s2_in.pre = in_box0 || in_box1;
         PAIR_POINT_POINT: s2_in.pre = (ax == bx) && (ay == by);
         default:          s2_in.pre = 1'b0;
      endcase
      s2_in.rneg = w0r < 0;
      s2_in.w0r  = w0r;
      if (s1_ff.pair == PAIR_BOX_CIRCLE) begin
         s2_in.w0x = clx;
         s2_in.w0y = cly;
      end else begin
         s2_in.w0x = bx - ax;
         s2_in.w0y = by - ay;
      end
      s2_in.w1x = bp - ax;
      s2_in.w1y = bq - ay;
      s2_in.pdx = ppx - psx;
      s2_in.pdy = ppy - psy;
      s2_in.pex = ptx - psx;
      s2_in.pey = pty - psy;
      for (int i = 0; i < 4; i++) begin
         s2_in.seg[i].adx = ex2[i] - ex1[i];
         s2_in.seg[i].ady = ey2[i] - ey1[i];
         s2_in.seg[i].bdx = bp - bx;
         s2_in.seg[i].bdy = bq - by;
         s2_in.seg[i].ox  = ex1[i] - bx;
         s2_in.seg[i].oy  = ey1[i] - by;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) s2_ff <= s2_in;
   end

   // Stage 3: all products for the circle distance and projection tests.
   always_comb begin
      s3_in.pair = s2_ff.pair;
      s3_in.pre  = s2_ff.pre;
      s3_in.rneg = s2_ff.rneg;
      s3_in.w0xx = smul(s2_ff.w0x, s2_ff.w0x);
      s3_in.w0yy = smul(s2_ff.w0y, s2_ff.w0y);
      s3_in.rr   = smul(s2_ff.w0r, s2_ff.w0r);
      s3_in.w1xx = smul(s2_ff.w1x, s2_ff.w1x);
      s3_in.w1yy = smul(s2_ff.w1y, s2_ff.w1y);
      s3_in.pxx  = smul(s2_ff.pdx, s2_ff.pdx);
      s3_in.pyy  = smul(s2_ff.pdy, s2_ff.pdy);
      s3_in.pxd  = smul(s2_ff.pex, s2_ff.pdx);
      s3_in.pyd  = smul(s2_ff.pey, s2_ff.pdy);
      s3_in.pc1  = smul(s2_ff.pdx, s2_ff.pey);
      s3_in.pc2  = smul(s2_ff.pdy, s2_ff.pex);
   end

   always_ff @(posedge clock) begin
      if (adv[3]) s3_ff <= s3_in;
   end

   // Stage 4: squared distances against the squared radius, length,
   // dot product and cross product of the projection.
   always_comb begin
      s4_in.pair = s3_ff.pair;
      s4_in.pre  = s3_ff.pre;
      s4_in.rneg = s3_ff.rneg;
      s4_in.w0d  = ext(s3_ff.w0xx) + ext(s3_ff.w0yy) - ext(s3_ff.rr);
      s4_in.w1d  = ext(s3_ff.w1xx) + ext(s3_ff.w1yy) - ext(s3_ff.rr);
      s4_in.len2 = ext(s3_ff.pxx) + ext(s3_ff.pyy);
      s4_in.dot  = ext(s3_ff.pxd) + ext(s3_ff.pyd);
      s4_in.dml  = ext(s3_ff.pxd) + ext(s3_ff.pyd) - ext(s3_ff.pxx) - ext(s3_ff.pyy);
      s4_in.cr   = ext(s3_ff.pc1) - ext(s3_ff.pc2);
      s4_in.rr   = s3_ff.rr;
   end

   always_ff @(posedge clock) begin
      if (adv[4]) s4_ff <= s4_in;
   end

   // Stage 5: distance and projection decisions, cross product magnitude.
   logic [SW-1:0] crabs;
   logic          len2nz, dotok;

   assign crabs  = s4_ff.cr[SW-1] ? (SW'(0) - s4_ff.cr) : s4_ff.cr;
   assign len2nz = s4_ff.len2 != '0;
   assign dotok  = !s4_ff.dot[SW-1] && nonpos(s4_ff.dml);

   always_comb begin
      s5_in.pair   = s4_ff.pair;
      s5_in.pre    = s4_ff.pre;
      s5_in.rneg   = s4_ff.rneg;
      s5_in.w0hit  = !s4_ff.rneg && nonpos(s4_ff.w0d);
      s5_in.w1hit  = !s4_ff.rneg && nonpos(s4_ff.w1d);
      s5_in.segpt  = len2nz && (s4_ff.cr == '0) && dotok;
      s5_in.projok = len2nz && dotok;
      s5_in.crmag  = crabs[PW-1:0];
      s5_in.len2m  = s4_ff.len2[PW-1:0];
      s5_in.rsq    = s4_ff.rr;
   end

   always_ff @(posedge clock) begin
      if (adv[5]) s5_ff <= s5_in;
   end

   // Segment crossing units for the box edges or a second line.
   for (genvar g = 0; g < 4; g++) begin : g_seg
      spc_seg_unit #(
         .COORD_BITS(COORD_BITS)
      ) u_seg (
         .clock (clock),
         .ctl   (seg_ctl),
         .adx   (s2_ff.seg[g].adx),
         .ady   (s2_ff.seg[g].ady),
         .bdx   (s2_ff.seg[g].bdx),
         .bdy   (s2_ff.seg[g].bdy),
         .ox    (s2_ff.seg[g].ox),
         .oy    (s2_ff.seg[g].oy),
         .hit   (seg_hit[g])
      );
   end

   // Stage 6: merge per-pair results; split partial products of the
   // squared cross product and of radius squared times length squared.
   logic [DW-1:0] crh, crl, rsh, rsl, lnh, lnl;

   assign crh = s5_ff.crmag[PW-1:DW];
   assign crl = s5_ff.crmag[DW-1:0];
   assign rsh = s5_ff.rsq[PW-1:DW];
   assign rsl = s5_ff.rsq[DW-1:0];
   assign lnh = s5_ff.len2m[PW-1:DW];
   assign lnl = s5_ff.len2m[DW-1:0];

   always_comb begin
      unique case (s5_ff.pair) inside
         PAIR_BOX_BOX, PAIR_BOX_POINT, PAIR_POINT_POINT: s6_in.base = s5_ff.pre;
         PAIR_BOX_LINE:     s6_in.base = s5_ff.pre || (seg_hit != '0);
         PAIR_BOX_CIRCLE, PAIR_CIRCLE_CIRCLE, PAIR_CIRCLE_POINT: begin
            s6_in.base = s5_ff.w0hit;
         end
         PAIR_CIRCLE_LINE:  s6_in.base = s5_ff.w0hit || s5_ff.w1hit;
         PAIR_LINE_LINE:    s6_in.base = seg_hit[0];
         PAIR_LINE_POINT:   s6_in.base = s5_ff.segpt;
         default:           s6_in.base = 1'b0;
      endcase
      s6_in.need = (s5_ff.pair == PAIR_CIRCLE_LINE) && !s5_ff.rneg && s5_ff.projok;
      s6_in.chh  = PW'(crh) * PW'(crh);
      s6_in.chl  = PW'(crh) * PW'(crl);
      s6_in.cll  = PW'(crl) * PW'(crl);
      s6_in.phh  = PW'(rsh) * PW'(lnh);
      s6_in.phl  = PW'(rsh) * PW'(lnl);
      s6_in.plh  = PW'(rsl) * PW'(lnh);
      s6_in.pll  = PW'(rsl) * PW'(lnl);
   end

   always_ff @(posedge clock) begin
      if (adv[6]) s6_ff <= s6_in;
   end

   // Stage 7: perpendicular distance test and the output register.
   logic [LW-1:0] lhs, rhs;

   assign lhs = (LW'(s6_ff.chh) << PW) + (LW'(s6_ff.chl) << (DW + 1)) + LW'(s6_ff.cll);
   assign rhs = (LW'(s6_ff.phh) << PW) + ((LW'(s6_ff.phl) + LW'(s6_ff.plh)) << DW)
              + LW'(s6_ff.pll);
   assign hit_in = s6_ff.base || (s6_ff.need && (lhs <= rhs));

   always_ff @(posedge clock) begin
      if (adv[7]) hit_ff <= hit_in;
   end

endmodule

// File: src/spc_checker.sv
// Port-level checks for the shape pair collision test block.
// Depends on nothing; bound to shape_pair_collision_test_top at the end.
module spc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_hit
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit))
      else $error("stalled response changed");

   // With no response waiting, every stage can move, so requests are taken.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // An accepted transaction reaches the output after seven stages
   // while the receiver keeps taking responses.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after pipeline latency");

endmodule

bind shape_pair_collision_test_top spc_checker u_spc_checker (.*);
